// ----- src/isoparametric_jacobian_gradient_macros.svh -----
// Assertion macros for the isoparametric Jacobian gradient block.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef ISOPARAMETRIC_JACOBIAN_GRADIENT_MACROS_SVH
`define ISOPARAMETRIC_JACOBIAN_GRADIENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IJG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IJG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ijg_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Jacobian gradient block.
// No dependencies; every other file of the block but the macros header imports this package.
package ijg_pkg;

  localparam int MAX_NODES = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DIV_CW    = 6;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;

  // Lane accumulate operations.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ADD,
    OP_SUB
  } lane_op_t;

  // One multiply request to a lane.
  typedef struct packed {
    logic       vld;
    lane_op_t   op;
    logic [1:0] sel;
  } lane_req_t;

  typedef logic [2:0][2:0][31:0] jmat_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_N1,
    S_N2,
    S_LWAIT,
    S_JCAP,
    S_COF,
    S_CWAIT,
    S_CCAP,
    S_DET,
    S_DWAIT,
    S_DCHK,
    S_DIVGO,
    S_DIVRUN,
    S_ERD,
    S_EMUL,
    S_EWAIT,
    S_EOUT
  } st_t;

  // Round a Q32.32 value to Q16.16 (half up) and clamp to 32-bit signed.
  function automatic logic [31:0] rnd_sat(input logic [63:0] x);
    logic signed [48:0] r;
    r = $signed({x[63], x[63:16]}) + $signed({48'd0, x[15]});
    if (r > 49'sd2147483647) begin
      return S32_MAX;
    end else if (r < -49'sd2147483648) begin
      return S32_MIN;
    end
    return r[31:0];
  endfunction

  // Next index modulo three.
  function automatic logic [1:0] inc3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

endpackage

// ----- src/ijg_lane.sv -----
// One multiply-accumulate lane: registered 32x32 product, then a saturating
// 64-bit accumulate into one of three accumulators. Depends on ijg_pkg.
module ijg_lane import ijg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  lane_req_t          req,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic [2:0][63:0]   acc
);

  logic [2:0][63:0]   acc_r;
  logic               vld_r;
  lane_op_t           op_r;
  logic [1:0]         sel_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;
  logic signed [64:0] base;
  logic signed [64:0] p65;
  logic signed [64:0] sum;
  logic [63:0]        acc_nxt;

  // Product stage.
  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    op_r   <= req.op;
    sel_r  <= req.sel;
  end

  // Saturating accumulate of the registered product.
  always_comb begin
    base = $signed({acc_r[sel_r][63], acc_r[sel_r]});
    p65  = {prod_r[63], prod_r};
    unique case (op_r)
      OP_LOAD: sum = p65;
      OP_ADD:  sum = base + p65;
      OP_SUB:  sum = base - p65;
      default: sum = p65;
    endcase
    if (sum[64] != sum[63]) begin
      acc_nxt = sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_nxt = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= req.vld;
      if (clr) begin
        acc_r <= '0;
      end else if (vld_r) begin
        acc_r[sel_r] <= acc_nxt;
      end
    end
  end

  assign acc = acc_r;

endmodule

// ----- src/ijg_div.sv -----
// Iterative signed 64 by unsigned 32 divider, one quotient bit per cycle,
// truncating toward zero, quotient clamped to 32-bit signed. Depends on ijg_pkg.
module ijg_div import ijg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic              run_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [32:0]       rem_r;
  logic [63:0]       q_r;
  logic [31:0]       dvs_r;
  logic              neg_r;
  logic [31:0]       quot_r;
  logic [32:0]       rem_sh;
  logic              ge;
  logic [63:0]       q_nxt;
  logic [31:0]       quot_nxt;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_r[31:0], q_r[63]};
    ge     = rem_sh >= {1'b0, dvs_r};
    q_nxt  = {q_r[62:0], ge};
  end

  // Sign and clamp of the final magnitude.
  always_comb begin
    if (neg_r) begin
      if ((|q_nxt[63:32]) || (q_nxt[31] && (|q_nxt[30:0]))) begin
        quot_nxt = S32_MIN;
      end else begin
        quot_nxt = 32'd0 - q_nxt[31:0];
      end
    end else begin
      quot_nxt = (|q_nxt[63:31]) ? S32_MAX : q_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[63] ? 64'd0 - dividend : dividend;
      neg_r <= dividend[63];
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      if (&cnt_r) begin
        quot_r <= quot_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- src/isoparametric_jacobian_gradient.sv -----
// Top level of the isoparametric Jacobian gradient block: sequencer, three
// multiply lanes, divider and result merge. Depends on ijg_pkg, ijg_lane, ijg_div and the macros header.
//
// Usage. A node request is taken at a rising edge with start high and busy
// low; it carries the node coordinates, local shape derivatives and a last
// node mark. For each node the three lanes (one per Jacobian row) each
// issue one product per cycle. A node beyond MAX_NODES is dropped; its
// last node mark still ends the point. On the last node the block
// finishes the point: Jacobian, cofactors and determinant, then 9 divides
// on the shared bit-serial divider, then one result per stored node. A
// non-positive determinant ends the point after the determinant with a
// single error result. Results appear on the out_ ports for one cycle
// with out_valid high; the receiver cannot stall. num_dims is written
// through cfg_we/cfg_wdata and is sampled when a point finishes.
// Synchronous reset clears the Jacobian sums and node count and sets
// num_dims to 3.
module isoparametric_jacobian_gradient import ijg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic [31:0] in_local_dx,
  input  logic [31:0] in_local_dy,
  input  logic [31:0] in_local_dz,
  input  logic        in_last_node,
  output logic        out_valid,
  output logic [2:0]  out_node_index,
  output logic [31:0] out_global_dx,
  output logic [31:0] out_global_dy,
  output logic [31:0] out_global_dz,
  output logic [31:0] out_det_value,
  output logic        out_bad_det,
  output logic        out_run_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  `include "isoparametric_jacobian_gradient_macros.svh"

  st_t                   st_r, st_nxt;
  logic [1:0]            num_dims_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  logic [2:0][31:0]      c_r, l_r;
  logic                  last_r;
  jmat_t                 j_r;
  logic [1:0]            n_r;
  logic [2:0]            step_r;
  logic [2:0][2:0][63:0] cof_r;
  logic [2:0][31:0]      c16_r;
  logic [31:0]           det_r;
  jmat_t                 inv_r;
  logic [1:0]            dk_r, dl_r;
  logic [NODE_W-1:0]     m_r;
  logic [2:0][31:0]      deriv_mem [MAX_NODES];
  logic [2:0][31:0]      rd_row_r;
  logic [2:0]            out_node_index_r;
  logic [2:0][31:0]      out_g_r;
  logic                  out_bad_det_r;
  logic                  out_run_end_r;

  logic                  accept;
  logic                  room;
  logic                  last_m;
  logic [31:0]           det_now;
  logic                  det_pos;
  logic [2:0][31:0]      in_c;
  lane_req_t             lane_req [3];
  logic [2:0][31:0]      lane_a, lane_b;
  logic [2:0][2:0][63:0] lane_acc;
  logic                  lane_clr;
  logic                  div_start;
  logic                  div_done;
  logic [31:0]           div_quot;

  // Operand pair for cofactor (i, j); ph 0 loads the first product, ph 1 subtracts.
  function automatic logic [63:0] cof_pair(input logic [1:0] i, input logic [1:0] j,
                                           input logic ph, input logic [1:0] n,
                                           input jmat_t jm);
    logic [31:0] a, b;
    logic [1:0]  i1, i2, j1, j2;
    i1 = inc3(i);
    i2 = inc3(i1);
    j1 = inc3(j);
    j2 = inc3(j1);
    a  = '0;
    b  = '0;
    if (n == 2'd3) begin
      if (!ph) begin
        a = jm[i1][j1];
        b = jm[i2][j2];
      end else begin
        a = jm[i1][j2];
        b = jm[i2][j1];
      end
    end else if (n == 2'd2 && !ph) begin
      unique case ({i, j})
        4'b0000: begin a = jm[1][1]; b = Q_ONE;     end
        4'b0001: begin a = jm[1][0]; b = Q_NEG_ONE; end
        4'b0100: begin a = jm[0][1]; b = Q_NEG_ONE; end
        4'b0101: begin a = jm[0][0]; b = Q_ONE;     end
        default: begin a = '0;       b = '0;        end
      endcase
    end else if (n == 2'd1 && !ph && i == 2'd0 && j == 2'd0) begin
      a = Q_ONE;
      b = Q_ONE;
    end
    return {a, b};
  endfunction

  assign in_c[0] = in_coord_x;
  assign in_c[1] = in_coord_y;
  assign in_c[2] = in_coord_z;

  assign busy    = (st_r != S_IDLE);
  assign accept  = start && !busy;
  assign room    = cnt_r < CNT_W'(MAX_NODES);
  assign last_m  = (CNT_W'(m_r) + CNT_W'(1)) == cnt_r;
  assign det_now = rnd_sat(lane_acc[0][0]);
  assign det_pos = $signed(det_now) > 32'sd0;

  // Lanes: lane u holds Jacobian row u, cofactor row u, or gradient u; lane 0 also forms the determinant.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    ijg_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .clr  (lane_clr),
      .req  (lane_req[g]),
      .op_a (lane_a[g]),
      .op_b (lane_b[g]),
      .acc  (lane_acc[g])
    );
  end

  // Shared divider for the inverse entries.
  ijg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(cof_r[dl_r][dk_r]),
    .divisor (det_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (room) begin
            st_nxt = S_N1;
          end else if (in_last_node) begin
            st_nxt = S_LWAIT;
          end
        end
      end
      S_N1:     st_nxt = S_N2;
      S_N2:     st_nxt = last_r ? S_LWAIT : S_IDLE;
      S_LWAIT:  st_nxt = S_JCAP;
      S_JCAP:   st_nxt = S_COF;
      S_COF:    st_nxt = (step_r == 3'd5) ? S_CWAIT : S_COF;
      S_CWAIT:  st_nxt = S_CCAP;
      S_CCAP:   st_nxt = S_DET;
      S_DET:    st_nxt = (step_r == 3'd2) ? S_DWAIT : S_DET;
      S_DWAIT:  st_nxt = S_DCHK;
      S_DCHK:   st_nxt = det_pos ? S_DIVGO : S_IDLE;
      S_DIVGO:  st_nxt = S_DIVRUN;
      S_DIVRUN: begin
        if (div_done) begin
          st_nxt = (dk_r == 2'd2 && dl_r == 2'd2) ? S_ERD : S_DIVGO;
        end
      end
      S_ERD:    st_nxt = S_EMUL;
      S_EMUL:   st_nxt = (step_r == 3'd2) ? S_EWAIT : S_EMUL;
      S_EWAIT:  st_nxt = S_EOUT;
      S_EOUT:   st_nxt = last_m ? S_IDLE : S_ERD;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // Lane requests, lane clear and divider start.
  always_comb begin
    lane_clr  = 1'b0;
    div_start = 1'b0;
    lane_a    = '0;
    lane_b    = '0;
    for (int i = 0; i < 3; i++) begin
      lane_req[i] = '{vld: 1'b0, op: OP_ADD, sel: 2'd0};
    end
    unique case (st_r)
      S_IDLE: begin
        if (accept && room) begin
          for (int i = 0; i < 3; i++) begin
            lane_req[i] = '{vld: 1'b1, op: OP_ADD, sel: 2'd0};
            lane_a[i]   = in_c[i];
            lane_b[i]   = in_local_dx;
          end
        end
      end
      S_N1, S_N2: begin
        for (int i = 0; i < 3; i++) begin
          lane_req[i] = '{vld: 1'b1, op: OP_ADD, sel: (st_r == S_N1) ? 2'd1 : 2'd2};
          lane_a[i]   = c_r[i];
          lane_b[i]   = (st_r == S_N1) ? l_r[1] : l_r[2];
        end
      end
      S_COF: begin
        for (int i = 0; i < 3; i++) begin
          lane_req[i] = '{vld: 1'b1, op: step_r[0] ? OP_SUB : OP_LOAD, sel: step_r[2:1]};
          {lane_a[i], lane_b[i]} = cof_pair(2'(i), step_r[2:1], step_r[0], n_r, j_r);
        end
      end
      S_DET: begin
        lane_req[0] = '{vld: 1'b1, op: (step_r == 3'd0) ? OP_LOAD : OP_ADD, sel: 2'd0};
        lane_a[0]   = (step_r[1:0] < n_r) ? j_r[0][step_r[1:0]] : '0;
        lane_b[0]   = c16_r[step_r[1:0]];
      end
      S_DCHK:  lane_clr  = !det_pos;
      S_DIVGO: div_start = 1'b1;
      S_EMUL: begin
        for (int i = 0; i < 3; i++) begin
          lane_req[i] = '{vld: 1'b1, op: (step_r == 3'd0) ? OP_LOAD : OP_ADD, sel: 2'd0};
          lane_a[i]   = inv_r[step_r[1:0]][i];
          lane_b[i]   = rd_row_r[step_r[1:0]];
        end
      end
      S_EOUT:  lane_clr  = last_m;
      default: lane_clr  = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      num_dims_r  <= 2'd3;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r == S_DCHK && !det_pos) || (st_r == S_EOUT);
      if (cfg_we) begin
        num_dims_r <= cfg_wdata;
      end
      if (st_r == S_IDLE && accept && room) begin
        cnt_r <= cnt_r + 1'b1;
      end else if ((st_r == S_DCHK && !det_pos) || (st_r == S_EOUT && last_m)) begin
        cnt_r <= '0;
      end
    end
  end

  // Local derivative store, one row per node.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && accept && room) begin
      deriv_mem[cnt_r[NODE_W-1:0]] <= {in_local_dz, in_local_dy, in_local_dx};
    end
    rd_row_r <= deriv_mem[m_r];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          c_r    <= in_c;
          l_r    <= {in_local_dz, in_local_dy, in_local_dx};
          last_r <= in_last_node;
        end
      end
      S_JCAP: begin
        for (int u = 0; u < 3; u++) begin
          for (int d = 0; d < 3; d++) begin
            j_r[u][d] <= rnd_sat(lane_acc[u][d]);
          end
        end
        n_r    <= (num_dims_r == 2'd0) ? 2'd1 : num_dims_r;
        step_r <= '0;
      end
      S_COF, S_DET, S_EMUL: step_r <= step_r + 3'd1;
      S_CCAP: begin
        cof_r  <= lane_acc;
        for (int j = 0; j < 3; j++) begin
          c16_r[j] <= rnd_sat(lane_acc[0][j]);
        end
        step_r <= '0;
      end
      S_DCHK: begin
        det_r <= det_now;
        dk_r  <= '0;
        dl_r  <= '0;
        m_r   <= '0;
        if (!det_pos) begin
          out_node_index_r <= '0;
          out_g_r          <= '0;
          out_bad_det_r    <= 1'b1;
          out_run_end_r    <= 1'b1;
        end
      end
      S_DIVRUN: begin
        if (div_done) begin
          inv_r[dk_r][dl_r] <= div_quot;
          if (dl_r == 2'd2) begin
            dl_r <= '0;
            dk_r <= dk_r + 2'd1;
          end else begin
            dl_r <= dl_r + 2'd1;
          end
        end
      end
      S_ERD: step_r <= '0;
      S_EOUT: begin
        out_node_index_r <= 3'(m_r);
        for (int l = 0; l < 3; l++) begin
          out_g_r[l] <= (2'(l) < n_r) ? rnd_sat(lane_acc[l][0]) : '0;
        end
        out_bad_det_r <= 1'b0;
        out_run_end_r <= last_m;
        m_r           <= m_r + 1'b1;
      end
      default: step_r <= step_r;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_node_index = out_node_index_r;
  assign out_global_dx  = out_g_r[0];
  assign out_global_dy  = out_g_r[1];
  assign out_global_dz  = out_g_r[2];
  assign out_det_value  = det_r;
  assign out_bad_det    = out_bad_det_r;
  assign out_run_end    = out_run_end_r;

  // Checks on sequencing and result formatting.
  `IJG_ASSERT_NXT(a_bad_det_result, st_r == S_DCHK && !det_pos, out_valid && out_bad_det && out_run_end, "bad determinant did not give an error result")
  `IJG_ASSERT_IMP(a_bad_det_zero, out_valid && out_bad_det, out_global_dx == 32'd0 && out_global_dy == 32'd0 && out_global_dz == 32'd0, "error result carries nonzero derivatives")
  `IJG_ASSERT_IMP(a_run_end_clear, out_valid && out_run_end, cnt_r == '0, "node count not cleared at end of point")
  `IJG_ASSERT_IMP(a_div_done_state, div_done, st_r == S_DIVRUN, "divider finished outside the divide phase")

endmodule

// ----- tb/isoparametric_jacobian_gradient_tb.sv -----
// Self-checking testbench for the isoparametric Jacobian gradient block.
// It drives node requests and checks each result against its own predictor.
// It depends on ijg_pkg and isoparametric_jacobian_gradient.
`timescale 1ns / 1ps

module isoparametric_jacobian_gradient_tb;
  import ijg_pkg::*;

  // One result of an integration point.
  typedef struct packed {
    bit [2:0]  idx;
    bit [31:0] gx, gy, gz, det;
    bit        bad, done;
  } grad_t;

  // Predicts the gradient results and checks them in order.
  class grad_scoreboard;
    longint jsum[9];
    int     dstore[24];
    int     nodes;
    bit [1:0] dims;
    grad_t  pending[$];
    int     errors;

    function new();
      clear_point();
      dims = 2'd3;
      errors = 0;
    endfunction

    function void clear_point();
      foreach (jsum[i]) jsum[i] = 0;
      nodes = 0;
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
    endfunction

    function longint to_q16(longint x);
      longint r;
      r = (x >>> 16) + ((x >>> 15) & 64'sd1);
      if (r > 64'sd2147483647) return 64'sd2147483647;
      if (r < -64'sd2147483648) return -64'sd2147483648;
      return r;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Note an accepted node request and predict the results it ends with.
    function void note_node(int c0, int c1, int c2, int l0, int l1, int l2, bit last);
      longint c[3], l[3], jm[3][3], cof[3][3], c16[3][3], inv[3][3];
      longint acc, det;
      int n, i1, i2, j1, j2;
      grad_t r;
      c[0] = c0; c[1] = c1; c[2] = c2;
      l[0] = l0; l[1] = l1; l[2] = l2;
      n = (dims == 0) ? 1 : dims;
      if (nodes < MAX_NODES) begin
        for (int u = 0; u < 3; u++)
          for (int d = 0; d < 3; d++)
            jsum[u*3+d] = add_sat(jsum[u*3+d], c[u] * l[d]);
        for (int k = 0; k < 3; k++) dstore[nodes*3+k] = int'(l[k]);
        nodes++;
      end
      if (!last) return;
      for (int u = 0; u < 3; u++)
        for (int d = 0; d < 3; d++) begin
          jm[u][d] = to_q16(jsum[u*3+d]);
          cof[u][d] = 0;
        end
      if (n == 1) begin
        cof[0][0] = 64'sd4294967296;
      end else if (n == 2) begin
        cof[0][0] = jm[1][1] * 65536;
        cof[0][1] = -jm[1][0] * 65536;
        cof[1][0] = -jm[0][1] * 65536;
        cof[1][1] = jm[0][0] * 65536;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            i1 = (i + 1) % 3; i2 = (i + 2) % 3;
            j1 = (j + 1) % 3; j2 = (j + 2) % 3;
            cof[i][j] = add_sat(jm[i1][j1] * jm[i2][j2], -(jm[i1][j2] * jm[i2][j1]));
          end
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) c16[i][j] = to_q16(cof[i][j]);
      acc = 0;
      for (int j = 0; j < n; j++) acc = add_sat(acc, jm[0][j] * c16[0][j]);
      det = to_q16(acc);
      r.det = det[31:0];
      if (det <= 0) begin
        // A determinant that is not positive ends the point with one error result.
        r.idx = 0; r.gx = 0; r.gy = 0; r.gz = 0; r.bad = 1; r.done = 1;
        pending.push_back(r);
        clear_point();
        return;
      end
      for (int k = 0; k < n; k++)
        for (int j = 0; j < n; j++) inv[k][j] = clamp32(cof[j][k] / det);
      for (int m = 0; m < nodes; m++) begin
        longint g[3];
        for (int j = 0; j < 3; j++) begin
          g[j] = 0;
          if (j < n) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc = add_sat(acc, inv[k][j] * longint'(dstore[m*3+k]));
            g[j] = to_q16(acc);
          end
        end
        r.idx = m[2:0]; r.gx = g[0][31:0]; r.gy = g[1][31:0]; r.gz = g[2][31:0];
        r.bad = 0; r.done = (m + 1 == nodes);
        pending.push_back(r);
      end
      clear_point();
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(grad_t got);
      grad_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request pending: node %0d", got.idx);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp idx %0d g %h %h %h det %h bad %b end %b, got idx %0d g %h %h %h det %h bad %b end %b",
                   exp_r.idx, exp_r.gx, exp_r.gy, exp_r.gz, exp_r.det, exp_r.bad, exp_r.done,
                   got.idx, got.gx, got.gy, got.gz, got.det, got.bad, got.done);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] cx = 0, cy = 0, cz = 0, lx = 0, ly = 0, lz = 0;
  logic        last = 0;
  logic        out_valid;
  logic [2:0]  out_node_index;
  logic [31:0] out_global_dx, out_global_dy, out_global_dz, out_det_value;
  logic        out_bad_det, out_run_end;
  logic        cfg_we = 0;
  logic [1:0]  cfg_wdata = 0;

  grad_scoreboard sb = new();
  int  quiet_cycles = 0;
  int  req_count = 0;
  bit  no_gaps = 0;

  always #5 clk = ~clk;

  isoparametric_jacobian_gradient u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_x(cx), .in_coord_y(cy), .in_coord_z(cz),
    .in_local_dx(lx), .in_local_dy(ly), .in_local_dz(lz), .in_last_node(last),
    .out_valid(out_valid), .out_node_index(out_node_index),
    .out_global_dx(out_global_dx), .out_global_dy(out_global_dy),
    .out_global_dz(out_global_dz), .out_det_value(out_det_value),
    .out_bad_det(out_bad_det), .out_run_end(out_run_end),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Monitor accepted requests and results; the watchdog counts quiet cycles.
  always @(posedge clk) begin
    grad_t got;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (start && !busy) begin
        sb.note_node(cx, cy, cz, lx, ly, lz, last);
        quiet_cycles = 0;
      end
      if (out_valid) begin
        got.idx = out_node_index; got.gx = out_global_dx; got.gy = out_global_dy;
        got.gz = out_global_dz; got.det = out_det_value;
        got.bad = out_bad_det; got.done = out_run_end;
        sb.check_result(got);
        quiet_cycles = 0;
      end
      if (quiet_cycles > 5000) begin
        $display("[isoparametric_jacobian_gradient] ERROR");
        $finish;
      end
    end
  end

  // Drive one node request and hold it until the block takes it.
  task automatic send_node(logic [31:0] a, b, c, d, e, f, logic fin);
    if (!no_gaps && $urandom_range(99) < 33) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1;
    cx <= a; cy <= b; cz <= c; lx <= d; ly <= e; lz <= f; last <= fin;
    do @(posedge clk); while (busy);
    req_count++;
  endtask

  // Wait for all results, let the block settle, then write num_dims.
  task automatic set_dims(logic [1:0] v);
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    sb.dims = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Send one integration point with well-formed or full-range content.
  task automatic send_point(int count, bit wide);
    logic [31:0] v[6];
    for (int k = 0; k < count; k++) begin
      for (int j = 0; j < 6; j++) begin
        if (wide) v[j] = $urandom;
        else if (j < 3) v[j] = $signed($urandom_range(8 << 16)) - (4 << 16);
        else v[j] = $signed($urandom_range(2 << 16)) - (1 << 16);
      end
      send_node(v[0], v[1], v[2], v[3], v[4], v[5], k == count - 1);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1;

    // Directed: a unit square in 2D, a 1D bar, an all-zero point and overflow cases.
    set_dims(2'd2);
    send_node(32'h0, 32'h0, 0, Q_NEG_ONE, Q_NEG_ONE, 0, 0);
    send_node(Q_ONE, 32'h0, 0, Q_ONE, 32'hFFFF_0000, 0, 0);
    send_node(Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, 0, 0);
    send_node(32'h0, Q_ONE, 0, Q_NEG_ONE, Q_ONE, 0, 1);
    set_dims(2'd1);
    send_node(32'h0, 0, 0, Q_NEG_ONE, 0, 0, 0);
    send_node(32'h0002_0000, 0, 0, Q_ONE, 0, 0, 1);
    send_node(Q_ONE, 0, 0, Q_ONE, 0, 0, 1);
    set_dims(2'd0);
    send_node(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1);
    send_node(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1);
    set_dims(2'd3);
    send_node(S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MAX, 1);
    send_node(32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 1);
    // More nodes than the store holds.
    send_point(10, 0);
    send_point(9, 1);

    // Random phases through every dimension setting.
    for (int ph = 0; ph < 8; ph++) begin
      set_dims(ph[1:0]);
      no_gaps = (ph == 4);
      while (req_count < 30 + (ph + 1) * 17)
        send_point($urandom_range(1, 9), $urandom_range(99) < 15);
    end
    no_gaps = 0;

    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[isoparametric_jacobian_gradient] OK");
    end else begin
      $display("[isoparametric_jacobian_gradient] ERROR");
    end
    $finish;
  end

endmodule
